[rtl/distinct_window_marker_finder_top_assert.svh]
// assertion macros for the distinct window marker finder
`ifndef DISTINCT_WINDOW_MARKER_FINDER_TOP_ASSERT_SVH
`define DISTINCT_WINDOW_MARKER_FINDER_TOP_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define DWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define DWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dwm_pkg.sv]
`default_nettype none

package dwm_pkg;

    // sizes of the block
    localparam int MAX_WINDOW        = 16;
    localparam int ALPHABET_SIZE     = 26;
    localparam int MAX_STRING_LENGTH = 4096;

    // field widths
    localparam int LETTER_W = 5;
    localparam int CFG_W    = 5;
    localparam int POS_W    = 13;
    localparam int CNT_W    = 5;
    localparam int REP_W    = 5;
    localparam int IDX_W    = $clog2(MAX_WINDOW);

    // window length after reset
    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = CFG_W'(4);

    // per-letter counter control
    typedef struct packed {
        logic clear;
        logic update;
        logic inc;
        logic dec;
    } t_cnt_ctrl;

    // per-letter counter contribution to the repeat total
    typedef struct packed {
        logic rep_inc;
        logic rep_dec;
    } t_cnt_flags;

endpackage

`default_nettype wire

[rtl/dwm_cell.sv]
`default_nettype none

module dwm_cell
    import dwm_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_shift,
    input  wire  [LETTER_W-1:0] i_letter,
    output logic [LETTER_W-1:0] o_letter
);

    logic [LETTER_W-1:0] r_letter;

    // one stage of the window, takes the neighbour's letter on each shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_letter <= i_letter;
        end
    end

    assign o_letter = r_letter;

endmodule

`default_nettype wire

[rtl/dwm_count_cell.sv]
`default_nettype none

module dwm_count_cell
    import dwm_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire  t_cnt_ctrl i_ctrl,
    output t_cnt_flags      o_flags
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // occurrences of this letter inside the window
    always_comb begin
        n_cnt = r_cnt;
        if (i_ctrl.clear) begin
            n_cnt = '0;
        end else if (i_ctrl.update) begin
            n_cnt = r_cnt + CNT_W'(i_ctrl.inc) - CNT_W'(i_ctrl.dec);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // repeat total changes: leaving letter drops a repeat, entering one adds
    // one; the same letter leaving and entering nets out
    assign o_flags.rep_dec = i_ctrl.dec && (r_cnt >= CNT_W'(2));
    assign o_flags.rep_inc = i_ctrl.inc &&
                             (i_ctrl.dec ? (r_cnt >= CNT_W'(2)) : (r_cnt != '0));

endmodule

`default_nettype wire

[rtl/distinct_window_marker_finder_top.sv]
// Distinct window marker finder.
// Input channel (i_in_valid / o_in_ready) takes one letter per item with
// i_last_char marking the final letter of a string. The output channel
// (o_out_valid / i_out_ready) returns marker_found and marker_position: one
// item when the last window_length letters are all distinct (position of the
// letter that completes it), or a not-found item at the end of a string with
// no marker. Letters after a report give nothing until the string ends.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes window_length
// (0 acts as 1, above 16 acts as 16) and clears the per-string state; write
// it only while the block is idle.
// Each result is registered into the output register, or into the skid register while the output is stalled.
// Throughput: one letter per cycle while input is not refused, as each accepted letter updates the row of
// window cells and the 26 letter counters together.
// Reset clears the counters, position count and output buffers and sets the
// window length to 4; no clearing pass is needed.
// When the receiver stalls, one more result is held in a skid register and
// input is refused while that register is full or a configuration write is
// offered.
`default_nettype none
`include "distinct_window_marker_finder_top_assert.svh"

module distinct_window_marker_finder_top
    import dwm_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [LETTER_W-1:0] i_letter,
    input  wire                 i_last_char,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_marker_found,
    output logic [POS_W-1:0]    o_marker_position,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [CFG_W-1:0]    i_window_length
);

    logic [CFG_W-1:0]    r_win_len;
    logic [POS_W-1:0]    r_chars_seen;
    logic [REP_W-1:0]    r_rep_total;
    logic                r_reported;
    logic                r_out_valid;
    logic                r_out_found;
    logic [POS_W-1:0]    r_out_pos;
    logic                r_skid_valid;
    logic                r_skid_found;
    logic [POS_W-1:0]    r_skid_pos;

    logic [CFG_W-1:0]    n_win_len;
    logic [POS_W-1:0]    n_chars_seen;
    logic [REP_W-1:0]    n_rep_total;
    logic                n_reported;
    logic                n_out_valid;
    logic                n_out_found;
    logic [POS_W-1:0]    n_out_pos;
    logic                n_skid_valid;
    logic                n_skid_found;
    logic [POS_W-1:0]    n_skid_pos;

    logic                cfg_fire;
    logic                in_fire;
    logic                out_fire;
    logic                step;
    logic                clear;
    logic                evict;
    logic [LETTER_W-1:0] sym;
    logic [LETTER_W-1:0] old_letter;
    logic [IDX_W-1:0]    tap_idx;
    logic                any_inc;
    logic                any_dec;
    logic                res_valid;
    logic                res_found;
    logic [POS_W-1:0]    res_pos;

    logic [LETTER_W-1:0] win_letter [MAX_WINDOW];
    t_cnt_ctrl           cnt_ctrl   [ALPHABET_SIZE];
    t_cnt_flags          cnt_flags  [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] rep_inc_vec;
    logic [ALPHABET_SIZE-1:0] rep_dec_vec;

    // handshakes, configuration takes priority over a letter
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_skid_valid && !i_cfg_valid;
    assign cfg_fire    = i_cfg_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = r_out_valid && i_out_ready;
    assign step        = in_fire && !r_reported;
    assign clear       = cfg_fire || (in_fire && i_last_char);

    // letters outside the alphabet count as the last letter
    assign sym = (i_letter >= LETTER_W'(ALPHABET_SIZE)) ?
                 LETTER_W'(ALPHABET_SIZE - 1) : i_letter;

    // letter leaving the window
    assign tap_idx    = IDX_W'(r_win_len - CFG_W'(1));
    assign old_letter = win_letter[tap_idx];
    assign evict      = r_chars_seen >= POS_W'(r_win_len);

    // row of window cells, newest letter in cell 0
    for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_win
        if (k == 0) begin : g_head
            dwm_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (step),
                .i_letter (sym),
                .o_letter (win_letter[k])
            );
        end else begin : g_body
            dwm_cell u_cell (
                .i_clk    (i_clk),
                .i_shift  (step),
                .i_letter (win_letter[k-1]),
                .o_letter (win_letter[k])
            );
        end
    end

    // one counter per letter
    for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cnt
        assign cnt_ctrl[i].clear  = clear;
        assign cnt_ctrl[i].update = step;
        assign cnt_ctrl[i].inc    = (sym == LETTER_W'(i));
        assign cnt_ctrl[i].dec    = evict && (old_letter == LETTER_W'(i));

        dwm_count_cell u_count (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cnt_ctrl[i]),
            .o_flags (cnt_flags[i])
        );

        assign rep_inc_vec[i] = cnt_flags[i].rep_inc;
        assign rep_dec_vec[i] = cnt_flags[i].rep_dec;
    end

    assign any_inc = |rep_inc_vec;
    assign any_dec = |rep_dec_vec;

    // per-string state and the result of this letter
    always_comb begin
        n_rep_total  = r_rep_total;
        n_chars_seen = r_chars_seen;
        n_reported   = r_reported;
        res_valid    = 1'b0;
        res_found    = 1'b0;
        res_pos      = '0;
        if (step) begin
            n_rep_total = r_rep_total + REP_W'(any_inc) - REP_W'(any_dec);
            if (r_chars_seen < POS_W'(MAX_STRING_LENGTH)) begin
                n_chars_seen = r_chars_seen + POS_W'(1);
            end
            if ((n_chars_seen >= POS_W'(r_win_len)) && (n_rep_total == '0)) begin
                res_valid  = 1'b1;
                res_found  = 1'b1;
                res_pos    = n_chars_seen;
                n_reported = 1'b1;
            end else if (i_last_char) begin
                res_valid = 1'b1;
            end
        end
        if (clear) begin
            n_rep_total  = '0;
            n_chars_seen = '0;
            n_reported   = 1'b0;
        end
    end

    // window length, out-of-range values saturated on write
    always_comb begin
        n_win_len = r_win_len;
        if (cfg_fire) begin
            if (i_window_length == '0) begin
                n_win_len = CFG_W'(1);
            end else if (i_window_length > CFG_W'(MAX_WINDOW)) begin
                n_win_len = CFG_W'(MAX_WINDOW);
            end else begin
                n_win_len = i_window_length;
            end
        end
    end

    // output register with skid stage
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_found  = r_out_found;
        n_out_pos    = r_out_pos;
        n_skid_valid = r_skid_valid;
        n_skid_found = r_skid_found;
        n_skid_pos   = r_skid_pos;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out_found  = r_skid_found;
                n_out_pos    = r_skid_pos;
                n_skid_valid = 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                n_out_valid = 1'b1;
                n_out_found = res_found;
                n_out_pos   = res_pos;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_found = res_found;
                n_skid_pos   = res_pos;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len    <= WINDOW_LENGTH_RESET;
            r_chars_seen <= '0;
            r_rep_total  <= '0;
            r_reported   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_win_len    <= n_win_len;
            r_chars_seen <= n_chars_seen;
            r_rep_total  <= n_rep_total;
            r_reported   <= n_reported;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_found  <= n_out_found;
        r_out_pos    <= n_out_pos;
        r_skid_found <= n_skid_found;
        r_skid_pos   <= n_skid_pos;
    end

    assign o_out_valid       = r_out_valid;
    assign o_marker_found    = r_out_found;
    assign o_marker_position = r_out_pos;

    // checks
    `DWM_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid, "skid full with output empty")
    `DWM_ASSERT_NOW(a_pos_matches_found, r_out_valid, (r_out_found == (r_out_pos != '0)), "found flag and position disagree")
    `DWM_ASSERT_NEXT(a_cfg_clears, cfg_fire, (r_chars_seen == '0) && (r_rep_total == '0) && !r_reported, "configuration write left string state")
    `DWM_ASSERT_NEXT(a_found_sets_reported, res_found && !i_last_char, r_reported, "marker reported but not latched")

endmodule

`default_nettype wire
